>>> rtl/core/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, constants and the control store of the Shell sort core.
// ----------------------------------------------------------------------------
package ssg_pkg;

	// Store geometry and data width.
	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	// Sedgewick 1986 increments, enough of them that three times the
	// largest one reaches any count that fits the store.
	localparam int GAP_NUM = 4;
	localparam int KW      = $clog2(GAP_NUM);

	typedef logic [CW-1:0] gap_t;

	localparam gap_t GAPS [GAP_NUM] = '{CW'(1), CW'(5), CW'(19), CW'(41)};

	// Control store address.
	typedef logic [3:0] step_t;

	localparam step_t ST_LOAD  = 4'd0;
	localparam step_t ST_INIT  = 4'd1;
	localparam step_t ST_PASS  = 4'd2;
	localparam step_t ST_RDI   = 4'd3;
	localparam step_t ST_HOLD  = 4'd4;
	localparam step_t ST_RDJ   = 4'd5;
	localparam step_t ST_CMP   = 4'd6;
	localparam step_t ST_STORE = 4'd7;
	localparam step_t ST_NEXTK = 4'd8;
	localparam step_t ST_DECK  = 4'd9;
	localparam step_t ST_RDE   = 4'd10;
	localparam step_t ST_LDO   = 4'd11;
	localparam step_t ST_WAIT  = 4'd12;
	localparam step_t ST_ELOOP = 4'd13;
	localparam step_t ST_DONE  = 4'd14;

	// Jump conditions. A step jumps to its target when the condition holds
	// and otherwise falls through to the next step.
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_LAST,
		COND_GAP_GE_N,
		COND_CONT,
		COND_I_MORE,
		COND_K_ZERO,
		COND_OUT_HELD,
		COND_E_MORE
	} cond_t;

	// One control word.
	typedef struct packed {
		logic  accept_in;
		logic  ld_k;
		logic  set_i;
		logic  rd_i;
		logic  ld_hold;
		logic  rd_j;
		logic  shift;
		logic  wr_hold;
		logic  inc_i;
		logic  dec_k;
		logic  rd_e;
		logic  ld_out;
		logic  clear;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Datapath flags seen by the sequencer.
	typedef struct packed {
		logic last_xfer;
		logic gap_ge_n;
		logic cont;
		logic i_more;
		logic k_zero;
		logic out_held;
		logic e_more;
	} status_t;

	// Index of the first pass gap: one below the first increment whose
	// triple reaches the count, but never below the first increment.
	function automatic logic [KW-1:0] start_index(logic [CW-1:0] n);
		logic [KW-1:0] s;
		logic          found;
		s     = KW'(GAP_NUM - 1);
		found = 1'b0;
		for (int x = 0; x < GAP_NUM; x++) begin
			if (!found && ((CW + 2)'(GAPS[x]) * (CW + 2)'(3) >= (CW + 2)'(n))) begin
				s     = KW'(x);
				found = 1'b1;
			end
		end
		return (s == '0) ? '0 : s - KW'(1);
	endfunction

	// Control store: load, gapped insertion passes, then emission.
	function automatic ctrl_t ucode(step_t pc);
		ctrl_t c;
		c        = '0;
		c.cond   = COND_NEVER;
		c.target = ST_LOAD;
		case (pc)
			ST_LOAD: begin
				c.accept_in = 1'b1;
				c.cond      = COND_NO_LAST;
				c.target    = ST_LOAD;
			end
			ST_INIT: begin
				c.ld_k = 1'b1;
			end
			ST_PASS: begin
				c.set_i  = 1'b1;
				c.cond   = COND_GAP_GE_N;
				c.target = ST_NEXTK;
			end
			ST_RDI: begin
				c.rd_i = 1'b1;
			end
			ST_HOLD: begin
				c.ld_hold = 1'b1;
			end
			ST_RDJ: begin
				c.rd_j = 1'b1;
			end
			ST_CMP: begin
				c.shift  = 1'b1;
				c.cond   = COND_CONT;
				c.target = ST_RDJ;
			end
			ST_STORE: begin
				c.wr_hold = 1'b1;
				c.inc_i   = 1'b1;
				c.cond    = COND_I_MORE;
				c.target  = ST_RDI;
			end
			ST_NEXTK: begin
				c.cond   = COND_K_ZERO;
				c.target = ST_RDE;
			end
			ST_DECK: begin
				c.dec_k  = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = ST_PASS;
			end
			ST_RDE: begin
				c.rd_e = 1'b1;
			end
			ST_LDO: begin
				c.ld_out = 1'b1;
			end
			ST_WAIT: begin
				c.cond   = COND_OUT_HELD;
				c.target = ST_WAIT;
			end
			ST_ELOOP: begin
				c.cond   = COND_E_MORE;
				c.target = ST_RDE;
			end
			ST_DONE: begin
				c.clear  = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = ST_LOAD;
			end
			default: begin
				c.cond   = COND_ALWAYS;
				c.target = ST_LOAD;
			end
		endcase
		return c;
	endfunction

endpackage

>>> rtl/core/shell_sort_sedgewick_gaps_core.sv
// ----------------------------------------------------------------------------
// shell_sort_sedgewick_gaps_core
// Collects signed words up to a marked last one, sorts them ascending by
// Shell sort with Sedgewick 1986 increments and streams them back out.
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    value, last
//   result   result_valid / result_stall sorted_value, last_out, overflow
//
// Loading takes one cycle per item; items are refused while sorting and
// emitting. Each insertion reads its element into a hold register, then
// reads and compares down its chain, shifting each larger element up by
// the gap, and writes the held element into the place reached. Emission
// loads each result into the output register and waits while it stalls.
// Reset clears the count, the overflow flag, the step counter and the
// output valid flag. A stalled result holds the sequencer in its wait step.
// ----------------------------------------------------------------------------
module shell_sort_sedgewick_gaps_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [31:0] value,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] sorted_value,
	output logic        last_out,
	output logic        overflow
);

	ssg_pkg::ctrl_t   ctrl;
	ssg_pkg::status_t st;

	logic [ssg_pkg::CW-1:0] count_q;
	logic                   ovf_q;
	logic [ssg_pkg::KW-1:0] k_q;
	logic [ssg_pkg::AW-1:0] i_q;
	logic [ssg_pkg::AW-1:0] pos_q;
	logic [ssg_pkg::CW-1:0] e_q;
	logic [ssg_pkg::DW-1:0] hold_q;
	logic                   result_valid_q;
	logic [ssg_pkg::DW-1:0] sorted_value_q;
	logic                   last_out_q;
	logic                   overflow_q;

	logic                   accept;
	logic                   room;
	logic                   gt;
	ssg_pkg::gap_t          gap;
	logic [ssg_pkg::AW-1:0] pos_minus;
	logic                   we;
	logic [ssg_pkg::AW-1:0] waddr;
	logic [ssg_pkg::DW-1:0] wdata;
	logic                   re;
	logic [ssg_pkg::AW-1:0] raddr;
	logic [ssg_pkg::DW-1:0] rdata;

	ssg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	ssg_ram #(
		.WIDTH (ssg_pkg::DW),
		.DEPTH (ssg_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Input transfer and datapath terms.
	assign item_stall = !ctrl.accept_in;
	assign accept     = item_valid && ctrl.accept_in;
	assign room       = count_q < ssg_pkg::CW'(ssg_pkg::DEPTH);
	assign gap        = ssg_pkg::GAPS[k_q];
	assign pos_minus  = pos_q - gap[ssg_pkg::AW-1:0];
	assign gt         = $signed(rdata) > $signed(hold_q);

	// Status flags for the sequencer.
	always_comb begin
		st.last_xfer = accept && last;
		st.gap_ge_n  = gap >= count_q;
		st.cont      = gt && ((ssg_pkg::CW + 1)'(pos_q) >= (ssg_pkg::CW + 1)'({gap, 1'b0}));
		st.i_more    = (ssg_pkg::CW'(i_q) + ssg_pkg::CW'(1)) < count_q;
		st.k_zero    = k_q == '0;
		st.out_held  = result_valid_q && result_stall;
		st.e_more    = e_q < count_q;
	end

	// Store ports: loading, shifting a larger element up, placing the held one.
	always_comb begin
		we    = (accept && room) || (ctrl.shift && gt) || ctrl.wr_hold;
		waddr = accept ? count_q[ssg_pkg::AW-1:0] : pos_q;
		wdata = accept ? value : (ctrl.shift ? rdata : hold_q);
		re    = ctrl.rd_i || ctrl.rd_j || ctrl.rd_e;
		raddr = ctrl.rd_i ? i_q : (ctrl.rd_j ? pos_minus : e_q[ssg_pkg::AW-1:0]);
	end

	// Item count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (room) begin
				count_q <= count_q + ssg_pkg::CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Pass, insertion and emission indexes.
	always_ff @(posedge clk) begin
		if (ctrl.ld_k) begin
			k_q <= ssg_pkg::start_index(count_q);
		end else if (ctrl.dec_k) begin
			k_q <= k_q - ssg_pkg::KW'(1);
		end
		if (ctrl.set_i) begin
			i_q <= gap[ssg_pkg::AW-1:0];
		end else if (ctrl.inc_i) begin
			i_q <= i_q + ssg_pkg::AW'(1);
		end
		if (ctrl.rd_i) begin
			pos_q <= i_q;
		end else if (ctrl.shift && gt) begin
			pos_q <= pos_minus;
		end
		if (ctrl.ld_hold) begin
			hold_q <= rdata;
		end
		if (ctrl.ld_k) begin
			e_q <= '0;
		end else if (ctrl.ld_out) begin
			e_q <= e_q + ssg_pkg::CW'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			sorted_value_q <= rdata;
			last_out_q     <= (e_q + ssg_pkg::CW'(1)) == count_q;
			overflow_q     <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_value = sorted_value_q;
	assign last_out     = last_out_q;
	assign overflow     = overflow_q;

	// The held element is always placed inside the loaded range.
	a_hold_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_hold |-> (ssg_pkg::CW'(pos_q) < count_q))
		else $error("held element placed beyond the loaded count");

	// A compare read never steps below the start of the store.
	a_read_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_j |-> (pos_q >= gap[ssg_pkg::AW-1:0]))
		else $error("compare read index went negative");

	// A result is only loaded into an empty output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ld_out |-> !result_valid_q)
		else $error("output register overwritten before transfer");

	// Loading resumes only after every result has been transferred.
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept_in |-> !result_valid_q)
		else $error("item accepted while a result is pending");

	// The count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !room |=> count_q == ssg_pkg::CW'(ssg_pkg::DEPTH) && ovf_q)
		else $error("dropped item changed the count or missed the flag");

endmodule

>>> rtl/core/ssg_ram.sv
// ----------------------------------------------------------------------------
// ssg_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ssg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ssg_seq.sv
// ----------------------------------------------------------------------------
// ssg_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module ssg_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  ssg_pkg::status_t st,
	output ssg_pkg::ctrl_t   ctrl
);

	ssg_pkg::step_t pc_q;
	logic           take;

	// Current control word.
	assign ctrl = ssg_pkg::ucode(pc_q);

	// Jump condition select.
	always_comb begin
		case (ctrl.cond)
			ssg_pkg::COND_NEVER:    take = 1'b0;
			ssg_pkg::COND_ALWAYS:   take = 1'b1;
			ssg_pkg::COND_NO_LAST:  take = !st.last_xfer;
			ssg_pkg::COND_GAP_GE_N: take = st.gap_ge_n;
			ssg_pkg::COND_CONT:     take = st.cont;
			ssg_pkg::COND_I_MORE:   take = st.i_more;
			ssg_pkg::COND_K_ZERO:   take = st.k_zero;
			ssg_pkg::COND_OUT_HELD: take = st.out_held;
			ssg_pkg::COND_E_MORE:   take = st.e_more;
			default:                take = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ssg_pkg::ST_LOAD;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + ssg_pkg::step_t'(1);
		end
	end

endmodule

>>> tb/sorted_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_stream_checker
// Watches both channels of the Shell sort core. It rebuilds every data set
// from the accepted item transfers and sorts it with the same gapped
// insertion passes. It then compares each result transfer, field by field
// and in order, against the words still due.
// ----------------------------------------------------------------------------
module sorted_stream_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic [ssg_pkg::DW-1:0] value,
	input  logic                   last,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [ssg_pkg::DW-1:0] sorted_value,
	input  logic                   last_out,
	input  logic                   overflow,
	output int                     failures,
	output int                     expected_left,
	output int                     sets_sorted,
	output int                     results_checked
);

	// One word of sorted output as it should appear on the result channel.
	typedef struct packed {
		logic [ssg_pkg::DW-1:0] word;
		logic                   final_word;
		logic                   dropped;
	} sorted_word_t;

	logic signed [ssg_pkg::DW-1:0] held_values [ssg_pkg::DEPTH];
	int                            held_count;
	logic                          items_dropped;
	sorted_word_t                  sorted_due [$];
	sorted_word_t                  head;
	int                            fail_tally;
	int                            set_tally;
	int                            result_tally;

	// Increment number s of the 1986 sequence: 1, 5, 19, 41, 109, ...
	function automatic int sedgewick_gap(int s);
		if (s % 2 == 1)
			return 8 * (1 << s) - 6 * (1 << ((s + 1) / 2)) + 1;
		return 9 * (1 << s) - 9 * (1 << (s / 2)) + 1;
	endfunction

	// Sorts the first n held words in place. The first pass uses the gap
	// just below the first one whose triple reaches n, and passes go down to 1.
	function automatic void sort_held_values(int n);
		int                            s;
		int                            gap;
		int                            j;
		logic signed [ssg_pkg::DW-1:0] pick;
		s = 0;
		while (s < 15 && 3 * sedgewick_gap(s) < n)
			s++;
		if (s > 0)
			s--;
		for (int k = s; k >= 0; k--) begin
			gap = sedgewick_gap(k);
			for (int i = gap; i < n; i++) begin
				pick = held_values[i];
				j    = i - gap;
				while (j >= 0 && held_values[j] > pick) begin
					held_values[j + gap] = held_values[j];
					j -= gap;
				end
				held_values[j + gap] = pick;
			end
		end
	endfunction

	// Both channels are sampled at the rising edge, before the core updates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count    = 0;
			items_dropped = 1'b0;
			sorted_due.delete();
			fail_tally    = 0;
			set_tally     = 0;
			result_tally  = 0;
		end else begin
			// A result transfer is checked against the oldest word still due.
			if (result_valid && !result_stall) begin
				result_tally++;
				if (sorted_due.size() == 0) begin
					$error("unexpected result transfer: sorted_value %0d, last_out %0b",
						$signed(sorted_value), last_out);
					fail_tally++;
				end else begin
					head = sorted_due.pop_front();
					if (sorted_value !== head.word) begin
						$error("sorted_value: expected %0d, got %0d",
							$signed(head.word), $signed(sorted_value));
						fail_tally++;
					end
					if (last_out !== head.final_word) begin
						$error("last_out: expected %0b, got %0b", head.final_word, last_out);
						fail_tally++;
					end
					if (overflow !== head.dropped) begin
						$error("overflow: expected %0b, got %0b", head.dropped, overflow);
						fail_tally++;
					end
				end
			end

			// An item transfer fills the store, or is dropped once it is full.
			// A marked last item closes the set and queues its sorted words.
			if (item_valid && !item_stall) begin
				if (held_count < ssg_pkg::DEPTH) begin
					held_values[held_count] = value;
					held_count++;
				end else begin
					items_dropped = 1'b1;
				end
				if (last) begin
					sort_held_values(held_count);
					for (int k = 0; k < held_count; k++)
						sorted_due.push_back('{word: held_values[k],
							final_word: (k == held_count - 1), dropped: items_dropped});
					set_tally++;
					held_count    = 0;
					items_dropped = 1'b0;
				end
			end
		end
		failures        <= fail_tally;
		expected_left   <= sorted_due.size();
		sets_sorted     <= set_tally;
		results_checked <= result_tally;
	end

endmodule

>>> tb/shell_sort_sedgewick_gaps_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_sort_sedgewick_gaps_core_tb
// Feeds data sets to the Shell sort core. A few directed sets cover the
// extreme words, duplicates and reversed order. Random sets follow, the
// first of them past the store depth. Both channels get random gaps, and the
// result side holds off once for a long stretch. The checker beside the core
// does the predicting and comparing.
// ----------------------------------------------------------------------------
module shell_sort_sedgewick_gaps_core_tb;

	localparam int                     CYCLE_LIMIT    = 400000;
	localparam int                     RANDOM_ITEMS   = 96;
	localparam int                     OVERFLOW_SET   = 0;
	localparam int                     HOLD_AT_RESULT = 30;
	localparam int                     LONG_HOLD      = 400;
	localparam int                     DRAIN_CYCLES   = 20;
	localparam logic [ssg_pkg::DW-1:0] MOST_NEGATIVE  = 32'h8000_0000;
	localparam logic [ssg_pkg::DW-1:0] MOST_POSITIVE  = 32'h7FFF_FFFF;
	localparam logic [ssg_pkg::DW-1:0] MINUS_ONE      = 32'hFFFF_FFFF;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	logic [ssg_pkg::DW-1:0] value        = '0;
	logic                   last         = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [ssg_pkg::DW-1:0] sorted_value;
	logic                   last_out;
	logic                   overflow;

	int failures;
	int expected_left;
	int sets_sorted;
	int results_checked;
	int items_sent  = 0;
	int cycle_count = 0;

	shell_sort_sedgewick_gaps_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow)
	);

	sorted_stream_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.value           (value),
		.last            (last),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.sorted_value    (sorted_value),
		.last_out        (last_out),
		.overflow        (overflow),
		.failures        (failures),
		.expected_left   (expected_left),
		.sets_sorted     (sets_sorted),
		.results_checked (results_checked)
	);

	// 50 MHz clock.
	always #10 clk = ~clk;

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly full random words, with some extremes and some small values
	// so that duplicates turn up.
	function automatic logic [ssg_pkg::DW-1:0] random_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEGATIVE;
					1: return MOST_POSITIVE;
					2: return '0;
					default: return MINUS_ONE;
				endcase
			end
			1: return ssg_pkg::DW'($urandom_range(0, 15)) - ssg_pkg::DW'(8);
			default: return $urandom;
		endcase
	endfunction

	// Offers one word and returns at the edge where its transfer happens.
	task automatic offer_word(input logic [ssg_pkg::DW-1:0] word, input logic closes_set,
		input bit calm);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= word;
		last       <= closes_set;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// Offers a whole data set, the final word marked last.
	task automatic offer_set(input logic [ssg_pkg::DW-1:0] words [$], input bit calm);
		for (int i = 0; i < words.size(); i++)
			offer_word(words[i], i == words.size() - 1, calm);
	endtask

	// Result side: a random stall before each transfer, stretches without
	// stalls, and one long hold-off while the item side keeps offering.
	initial begin
		int hold;
		int calm_left;
		int taken;
		calm_left = 0;
		taken     = 0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT_RESULT) begin
				hold = LONG_HOLD;
			end else if (calm_left > 0) begin
				hold = 0;
				calm_left--;
			end else begin
				hold = $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0)
					calm_left = 24;
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			taken++;
		end
	end

	// Item side and verdict.
	initial begin
		logic [ssg_pkg::DW-1:0] words [$];
		int                     random_sent;
		int                     set_index;
		int                     set_size;
		bit                     calm;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets: a lone most negative word, the extremes, a sorted
		// pair, a reversed run and a set full of duplicates.
		words = '{MOST_NEGATIVE};
		offer_set(words, 1'b0);
		words = '{MOST_POSITIVE, MOST_NEGATIVE, 32'd0, MINUS_ONE, 32'd1, MOST_NEGATIVE,
			MOST_POSITIVE};
		offer_set(words, 1'b0);
		words = '{32'hFFFF_FFFB, 32'd3};
		offer_set(words, 1'b1);
		words.delete();
		for (int i = 0; i < 8; i++)
			words.push_back(ssg_pkg::DW'((3 - i) * 1000));
		offer_set(words, 1'b0);
		words = '{32'd2, 32'd2, 32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFE};
		offer_set(words, 1'b0);

		// Hold the item side until every directed result is back.
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);

		// Random sets, mostly small. The first runs two words past the store
		// depth, so the word marked last is itself dropped. Later sets are
		// trimmed so the random words add up to the planned total.
		random_sent = 0;
		set_index   = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (set_index == OVERFLOW_SET) begin
				set_size = ssg_pkg::DEPTH + 2;
			end else begin
				if ($urandom_range(0, 4) == 0)
					set_size = $urandom_range(13, ssg_pkg::DEPTH);
				else
					set_size = $urandom_range(1, 12);
				if (set_size > RANDOM_ITEMS - random_sent)
					set_size = RANDOM_ITEMS - random_sent;
			end
			words.delete();
			for (int i = 0; i < set_size; i++)
				words.push_back(random_word());
			calm = ($urandom_range(0, 3) == 0);
			offer_set(words, calm);
			random_sent += set_size;
			set_index++;
		end

		// Let the last set drain, then allow for any stray result.
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result transfers from %0d sorted sets, fed by %0d item transfers.",
			results_checked, sets_sorted, items_sent);
		$display("Sets ranged from one word to past the %0d-entry store, under random stalls.",
			ssg_pkg::DEPTH);
		if (failures == 0 && expected_left == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_ram.sv
rtl/core/ssg_seq.sv
rtl/core/shell_sort_sedgewick_gaps_core.sv
tb/sorted_stream_checker.sv
tb/shell_sort_sedgewick_gaps_core_tb.sv
